// File: hdl/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared request and status codes for the pair handler table.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    // request codes
    localparam req_t REQ_REGISTER   = 2'd0;
    localparam req_t REQ_REMOVE     = 2'd1;
    localparam req_t REQ_REMOVE_ALL = 2'd2;
    localparam req_t REQ_INVOKE     = 2'd3;

    // status codes
    localparam status_t STAT_DONE      = 3'd0;
    localparam status_t STAT_DUP       = 3'd1;
    localparam status_t STAT_FULL      = 3'd2;
    localparam status_t STAT_NULL      = 3'd3;
    localparam status_t STAT_NOT_FOUND = 3'd4;

endpackage

// File: hdl/pht_cell.sv
// ----------------------------------------------------------------------------
// pht_cell
// One table slot of the rotating chain: holds a pair and its handler and
// takes its neighbor's contents on every shift.
// ----------------------------------------------------------------------------
module pht_cell #(
    parameter int ID_BITS      = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic                    clk,
    input  logic                    shift,
    input  logic [ID_BITS-1:0]      first_in,
    input  logic [ID_BITS-1:0]      second_in,
    input  logic [HANDLER_BITS-1:0] handler_in,
    output logic [ID_BITS-1:0]      first_q,
    output logic [ID_BITS-1:0]      second_q,
    output logic [HANDLER_BITS-1:0] handler_q
);

    logic [ID_BITS-1:0]      first_reg;
    logic [ID_BITS-1:0]      second_reg;
    logic [HANDLER_BITS-1:0] handler_reg;

    // slot storage, payload only
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            first_reg   <= first_in;
            second_reg  <= second_in;
            handler_reg <= handler_in;
        end
    end

    assign first_q   = first_reg;
    assign second_q  = second_reg;
    assign handler_q = handler_reg;

endmodule

// File: hdl/pair_handler_table.sv
// ----------------------------------------------------------------------------
// pair_handler_table
// Table of ordered (first id, second id, handler) pairs built as a rotating
// chain of slot cells, with register, remove, remove-all and invoke requests.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every request except
// a register with a null id runs one or more full turns of the slot chain,
// with the head slot compared in every cycle: register and invoke take
// one turn, a remove that hits takes two, and remove-all takes one turn
// per removed entry plus one. A register with a null id
// answers the cycle after it is taken. Results leave through registers, one
// per cycle on done for a single cycle, and there is no way to hold them off;
// invoke gives up to two results back to back, the last one flagged. busy
// drops in the cycle the final result shows, so the next item may be taken
// there. The table comes up empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module pair_handler_table #(
    parameter int ENTRIES      = 16,
    parameter int ID_BITS      = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  pht_pkg::req_t           req_type,
    input  logic [ID_BITS-1:0]      first_id,
    input  logic [ID_BITS-1:0]      second_id,
    input  logic [HANDLER_BITS-1:0] handler_in,
    output logic                    busy,
    output logic                    done,
    output pht_pkg::status_t        status,
    output logic                    match_valid,
    output logic [HANDLER_BITS-1:0] handler_out,
    output logic                    reversed,
    output logic                    last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EMIT2 = 2'd2;

    // chain taps
    logic [ID_BITS-1:0]      cell_first   [ENTRIES];
    logic [ID_BITS-1:0]      cell_second  [ENTRIES];
    logic [HANDLER_BITS-1:0] cell_handler [ENTRIES];

    // control state
    logic [1:0]             state_reg, state_next;
    pht_pkg::req_t          req_reg, req_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    logic                   final_pass_reg, final_pass_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic                   any_reg, any_next;
    logic                   dup_reg, dup_next;
    logic                   fwd_reg, fwd_next;
    logic [IDX_W-1:0]       fwd_idx_reg, fwd_idx_next;
    logic                   rev_reg, rev_next;
    logic [IDX_W-1:0]       rev_idx_reg, rev_idx_next;
    logic                   done_reg, done_next;

    // payload state
    logic [ID_BITS-1:0]      a_reg, a_next;
    logic [ID_BITS-1:0]      b_reg, b_next;
    logic [HANDLER_BITS-1:0] h_reg, h_next;
    logic [ID_BITS-1:0]      hold_first_reg, hold_first_next;
    logic [ID_BITS-1:0]      hold_second_reg, hold_second_next;
    logic [HANDLER_BITS-1:0] hold_handler_reg, hold_handler_next;
    logic [ID_BITS-1:0]      cap_first_reg, cap_first_next;
    logic [ID_BITS-1:0]      cap_second_reg, cap_second_next;
    logic [HANDLER_BITS-1:0] cap_handler_reg, cap_handler_next;
    logic [HANDLER_BITS-1:0] fwd_h_reg, fwd_h_next;
    logic [HANDLER_BITS-1:0] rev_h_reg, rev_h_next;
    logic [HANDLER_BITS-1:0] sec_h_reg, sec_h_next;
    logic                    sec_rev_reg, sec_rev_next;
    pht_pkg::status_t        status_reg, status_next;
    logic                    match_reg, match_next;
    logic [HANDLER_BITS-1:0] handler_reg, handler_next;
    logic                    rev_out_reg, rev_out_next;
    logic                    last_reg, last_next;

    // head slot after pending write or insert
    logic                    shift;
    logic                    wr_hit, ins_hit;
    logic [ID_BITS-1:0]      cur_first, cur_second;
    logic [HANDLER_BITS-1:0] cur_handler;
    logic                    in_tab, is_last_slot, pass_end;
    logic                    eq_fwd, eq_rev, eq_any, rm_hit;
    logic                    found_f, fwd_f, rev_f, fwd_first;
    logic [IDX_W-1:0]        idx_f, fwd_i_f, rev_i_f;
    logic [ID_BITS-1:0]      capf_first, capf_second;
    logic [HANDLER_BITS-1:0] capf_handler, fwd_h_f, rev_h_f;

    assign shift = (state_reg == S_SCAN);

    // chain of slot cells, rotating toward the head
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        if (k == ENTRIES - 1)
        begin : g_tail
            pht_cell #(
                .ID_BITS      (ID_BITS),
                .HANDLER_BITS (HANDLER_BITS)
            ) u_cell (
                .clk        (clk),
                .shift      (shift),
                .first_in   (cur_first),
                .second_in  (cur_second),
                .handler_in (cur_handler),
                .first_q    (cell_first[k]),
                .second_q   (cell_second[k]),
                .handler_q  (cell_handler[k])
            );
        end
        else
        begin : g_body
            pht_cell #(
                .ID_BITS      (ID_BITS),
                .HANDLER_BITS (HANDLER_BITS)
            ) u_cell (
                .clk        (clk),
                .shift      (shift),
                .first_in   (cell_first[k+1]),
                .second_in  (cell_second[k+1]),
                .handler_in (cell_handler[k+1]),
                .first_q    (cell_first[k]),
                .second_q   (cell_second[k]),
                .handler_q  (cell_handler[k])
            );
        end
    end

    // head value: insert on register, or the moved last entry on removal
    always_comb
    begin
        wr_hit  = wr_pend_reg && (step_reg == wr_idx_reg);
        ins_hit = (req_reg == pht_pkg::REQ_REGISTER) && !dup_reg
                  && (CNT_W'(step_reg) == cnt_reg);
        if (ins_hit)
        begin
            cur_first   = a_reg;
            cur_second  = b_reg;
            cur_handler = h_reg;
        end
        else if (wr_hit)
        begin
            cur_first   = hold_first_reg;
            cur_second  = hold_second_reg;
            cur_handler = hold_handler_reg;
        end
        else
        begin
            cur_first   = cell_first[0];
            cur_second  = cell_second[0];
            cur_handler = cell_handler[0];
        end
    end

    // head compares
    always_comb
    begin
        in_tab       = CNT_W'(step_reg) < cnt_reg;
        is_last_slot = (CNT_W'(step_reg) + CNT_W'(1)) == cnt_reg;
        pass_end     = step_reg == IDX_W'(ENTRIES - 1);
        eq_fwd       = in_tab && (cur_first == a_reg) && (cur_second == b_reg);
        eq_rev       = in_tab && (cur_first == b_reg) && (cur_second == a_reg);
        eq_any       = in_tab && ((cur_first == a_reg) || (cur_second == a_reg));
        rm_hit       = !final_pass_reg && !found_reg
                       && ((req_reg == pht_pkg::REQ_REMOVE) ? eq_fwd : eq_any);
        found_f      = found_reg || rm_hit;
        idx_f        = found_reg ? match_idx_reg : step_reg;
        capf_first   = is_last_slot ? cur_first : cap_first_reg;
        capf_second  = is_last_slot ? cur_second : cap_second_reg;
        capf_handler = is_last_slot ? cur_handler : cap_handler_reg;
        fwd_f        = fwd_reg || eq_fwd;
        fwd_i_f      = fwd_reg ? fwd_idx_reg : step_reg;
        fwd_h_f      = fwd_reg ? fwd_h_reg : cur_handler;
        rev_f        = rev_reg || eq_rev;
        rev_i_f      = rev_reg ? rev_idx_reg : step_reg;
        rev_h_f      = rev_reg ? rev_h_reg : cur_handler;
        fwd_first    = fwd_f && (!rev_f || (fwd_i_f <= rev_i_f));
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        step_next         = step_reg;
        cnt_next          = cnt_reg;
        wr_pend_next      = wr_pend_reg;
        wr_idx_next       = wr_idx_reg;
        final_pass_next   = final_pass_reg;
        found_next        = found_reg;
        match_idx_next    = match_idx_reg;
        any_next          = any_reg;
        dup_next          = dup_reg;
        fwd_next          = fwd_reg;
        fwd_idx_next      = fwd_idx_reg;
        rev_next          = rev_reg;
        rev_idx_next      = rev_idx_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        h_next            = h_reg;
        hold_first_next   = hold_first_reg;
        hold_second_next  = hold_second_reg;
        hold_handler_next = hold_handler_reg;
        cap_first_next    = cap_first_reg;
        cap_second_next   = cap_second_reg;
        cap_handler_next  = cap_handler_reg;
        fwd_h_next        = fwd_h_reg;
        rev_h_next        = rev_h_reg;
        sec_h_next        = sec_h_reg;
        sec_rev_next      = sec_rev_reg;
        done_next         = 1'b0;
        status_next       = pht_pkg::STAT_DONE;
        match_next        = 1'b0;
        handler_next      = '0;
        rev_out_next      = 1'b0;
        last_next         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req_type;
                    a_next          = first_id;
                    b_next          = second_id;
                    h_next          = handler_in;
                    step_next       = '0;
                    wr_pend_next    = 1'b0;
                    final_pass_next = 1'b0;
                    found_next      = 1'b0;
                    any_next        = 1'b0;
                    dup_next        = 1'b0;
                    fwd_next        = 1'b0;
                    rev_next        = 1'b0;
                    if ((req_type == pht_pkg::REQ_REGISTER)
                        && ((first_id == '0) || (second_id == '0)))
                    begin
                        done_next   = 1'b1;
                        status_next = pht_pkg::STAT_NULL;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                step_next = pass_end ? '0 : step_reg + IDX_W'(1);
                if (rm_hit)
                begin
                    found_next     = 1'b1;
                    match_idx_next = step_reg;
                end
                if (is_last_slot)
                begin
                    cap_first_next   = cur_first;
                    cap_second_next  = cur_second;
                    cap_handler_next = cur_handler;
                end
                if ((req_reg == pht_pkg::REQ_REGISTER) && eq_fwd)
                begin
                    dup_next = 1'b1;
                end
                if (eq_fwd && !fwd_reg)
                begin
                    fwd_next     = 1'b1;
                    fwd_idx_next = step_reg;
                    fwd_h_next   = cur_handler;
                end
                if (eq_rev && !rev_reg)
                begin
                    rev_next     = 1'b1;
                    rev_idx_next = step_reg;
                    rev_h_next   = cur_handler;
                end

                // end of one full turn: chain is back in table order
                if (pass_end)
                begin
                    found_next   = 1'b0;
                    wr_pend_next = 1'b0;
                    case (req_reg)
                        pht_pkg::REQ_REGISTER:
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                            if (dup_reg || eq_fwd)
                            begin
                                status_next = pht_pkg::STAT_DUP;
                            end
                            else if (cnt_reg == CNT_W'(ENTRIES))
                            begin
                                status_next = pht_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end

                        pht_pkg::REQ_REMOVE, pht_pkg::REQ_REMOVE_ALL:
                        begin
                            if (found_f && !final_pass_reg)
                            begin
                                // move the last entry into the hit slot next turn
                                wr_pend_next      = 1'b1;
                                wr_idx_next       = idx_f;
                                hold_first_next   = capf_first;
                                hold_second_next  = capf_second;
                                hold_handler_next = capf_handler;
                                cnt_next          = cnt_reg - CNT_W'(1);
                                any_next          = 1'b1;
                                final_pass_next   = (req_reg == pht_pkg::REQ_REMOVE);
                            end
                            else
                            begin
                                state_next  = S_IDLE;
                                done_next   = 1'b1;
                                status_next = any_reg ? pht_pkg::STAT_DONE
                                                      : pht_pkg::STAT_NOT_FOUND;
                            end
                        end

                        default:
                        begin
                            // invoke
                            done_next = 1'b1;
                            if (!fwd_f && !rev_f)
                            begin
                                state_next  = S_IDLE;
                                status_next = pht_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                match_next   = 1'b1;
                                handler_next = fwd_first ? fwd_h_f : rev_h_f;
                                rev_out_next = !fwd_first;
                                sec_h_next   = rev_h_f;
                                sec_rev_next = 1'b1;
                                if (fwd_f && rev_f)
                                begin
                                    state_next = S_EMIT2;
                                    last_next  = 1'b0;
                                    if (!fwd_first)
                                    begin
                                        sec_h_next   = fwd_h_f;
                                        sec_rev_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end

            S_EMIT2:
            begin
                state_next   = S_IDLE;
                done_next    = 1'b1;
                match_next   = 1'b1;
                handler_next = sec_h_reg;
                rev_out_next = sec_rev_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= pht_pkg::REQ_REGISTER;
            step_reg       <= '0;
            cnt_reg        <= '0;
            wr_pend_reg    <= 1'b0;
            wr_idx_reg     <= '0;
            final_pass_reg <= 1'b0;
            found_reg      <= 1'b0;
            match_idx_reg  <= '0;
            any_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            fwd_reg        <= 1'b0;
            fwd_idx_reg    <= '0;
            rev_reg        <= 1'b0;
            rev_idx_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            wr_pend_reg    <= wr_pend_next;
            wr_idx_reg     <= wr_idx_next;
            final_pass_reg <= final_pass_next;
            found_reg      <= found_next;
            match_idx_reg  <= match_idx_next;
            any_reg        <= any_next;
            dup_reg        <= dup_next;
            fwd_reg        <= fwd_next;
            fwd_idx_reg    <= fwd_idx_next;
            rev_reg        <= rev_next;
            rev_idx_reg    <= rev_idx_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        b_reg            <= b_next;
        h_reg            <= h_next;
        hold_first_reg   <= hold_first_next;
        hold_second_reg  <= hold_second_next;
        hold_handler_reg <= hold_handler_next;
        cap_first_reg    <= cap_first_next;
        cap_second_reg   <= cap_second_next;
        cap_handler_reg  <= cap_handler_next;
        fwd_h_reg        <= fwd_h_next;
        rev_h_reg        <= rev_h_next;
        sec_h_reg        <= sec_h_next;
        sec_rev_reg      <= sec_rev_next;
        status_reg       <= status_next;
        match_reg        <= match_next;
        handler_reg      <= handler_next;
        rev_out_reg      <= rev_out_next;
        last_reg         <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign match_valid = match_reg;
    assign handler_out = handler_reg;
    assign reversed    = rev_out_reg;
    assign last        = last_reg;

endmodule

// File: hdl/pht_checker.sv
// ----------------------------------------------------------------------------
// pht_checker
// Port-level checks on the pair handler table result stream.
// ----------------------------------------------------------------------------
module pht_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input pht_pkg::status_t status,
    input logic             match_valid,
    input logic             reversed,
    input logic             last
);

    // a taken item either starts work or answers at once
    a_start_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("taken item neither busy nor answered");

    // a match always reports success
    a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && match_valid |-> status == pht_pkg::STAT_DONE)
        else $error("match result with failing status");

    // a non-match result is alone and final
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && !match_valid |-> last && !reversed)
        else $error("non-match result not final");

    // a run that is not over continues in the next cycle
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done && match_valid && busy == 1'b0)
        else $error("result run broken");

endmodule

bind pair_handler_table pht_checker u_pht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .match_valid (match_valid),
    .reversed    (reversed),
    .last        (last)
);
